>>> rtl/aes_pkg.sv
// AES-128 package: S-box tables, GF(2^8) helpers, round transforms.
// Used by every module of the block cipher; depends on nothing.
package aes_pkg;

   localparam int unsigned NumRounds = 10;
   localparam int unsigned CsrIndexWidth = 1;
   localparam logic [CsrIndexWidth-1:0] CsrKeyHigh = 1'b0;
   localparam logic [CsrIndexWidth-1:0] CsrKeyLow = 1'b1;
   localparam logic OpEncrypt = 1'b0;
   localparam logic OpDecrypt = 1'b1;

   localparam logic [7:0] RCON [NumRounds] = '{
      8'h01, 8'h02, 8'h04, 8'h08, 8'h10, 8'h20, 8'h40, 8'h80, 8'h1b, 8'h36};

   localparam logic [7:0] FWD_BOX [256] = '{
   8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
   8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
   8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
   8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
   8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
   8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
   8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
   8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
   8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
   8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
   8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
   8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
   8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
   8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
   8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
   8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};

   localparam logic [7:0] REV_BOX [256] = '{
   8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
   8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
   8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
   8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
   8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
   8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
   8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
   8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
   8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
   8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
   8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
   8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
   8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
   8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
   8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
   8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d};

   // Byte n of a 128-bit word sits at bits 127-8n downto 120-8n.
   function automatic logic [7:0] get_byte(input logic [127:0] w, input int unsigned n);
      get_byte = w[127 - 8*n -: 8];
   endfunction

   function automatic logic [7:0] xtime(input logic [7:0] b);
      xtime = {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
   endfunction

   function automatic logic [31:0] mix_col(input logic [31:0] c, input logic inv);
      logic [7:0] a [4];
      logic [7:0] x2 [4];
      logic [7:0] x4 [4];
      logic [7:0] x8 [4];
      logic [7:0] m2 [4];
      logic [7:0] m3 [4];
      logic [7:0] m9 [4];
      logic [7:0] mb [4];
      logic [7:0] md [4];
      logic [7:0] me [4];
      logic [7:0] r;
      for (int k = 0; k < 4; k++) begin
         a[k] = c[31 - 8*k -: 8];
         x2[k] = xtime(a[k]);
         x4[k] = xtime(x2[k]);
         x8[k] = xtime(x4[k]);
         m2[k] = x2[k];
         m3[k] = x2[k] ^ a[k];
         m9[k] = x8[k] ^ a[k];
         mb[k] = x8[k] ^ x2[k] ^ a[k];
         md[k] = x8[k] ^ x4[k] ^ a[k];
         me[k] = x8[k] ^ x4[k] ^ x2[k];
      end
      mix_col = '0;
      for (int row = 0; row < 4; row++) begin
         if (inv) begin
            r = me[row] ^ mb[(row+1)%4] ^ md[(row+2)%4] ^ m9[(row+3)%4];
         end else begin
            r = m2[row] ^ m3[(row+1)%4] ^ a[(row+2)%4] ^ a[(row+3)%4];
         end
         mix_col[31 - 8*row -: 8] = r;
      end
   endfunction

   // Next round key; rc is the round constant of that step.
   function automatic logic [127:0] key_step(input logic [127:0] k, input logic [7:0] rc);
      logic [31:0] w [4];
      logic [31:0] t;
      for (int i = 0; i < 4; i++) begin
         w[i] = k[127 - 32*i -: 32];
      end
      t = {FWD_BOX[w[3][23:16]] ^ rc, FWD_BOX[w[3][15:8]], FWD_BOX[w[3][7:0]],
           FWD_BOX[w[3][31:24]]};
      w[0] = w[0] ^ t;
      w[1] = w[1] ^ w[0];
      w[2] = w[2] ^ w[1];
      w[3] = w[3] ^ w[2];
      key_step = {w[0], w[1], w[2], w[3]};
   endfunction

   // Previous round key from the one after it.
   function automatic logic [127:0] key_back(input logic [127:0] k, input logic [7:0] rc);
      logic [31:0] w [4];
      logic [31:0] p [4];
      logic [31:0] t;
      for (int i = 0; i < 4; i++) begin
         w[i] = k[127 - 32*i -: 32];
      end
      p[3] = w[3] ^ w[2];
      p[2] = w[2] ^ w[1];
      p[1] = w[1] ^ w[0];
      t = {FWD_BOX[p[3][23:16]] ^ rc, FWD_BOX[p[3][15:8]], FWD_BOX[p[3][7:0]],
           FWD_BOX[p[3][31:24]]};
      p[0] = w[0] ^ t;
      key_back = {p[0], p[1], p[2], p[3]};
   endfunction

   // One round minus the key add; the column mix is dropped in the last round and for inverse.
   function automatic logic [127:0] round_core(input logic [127:0] s, input logic inv,
                                               input logic last);
      logic [127:0] sh;
      logic [127:0] sb;
      logic [127:0] mc;
      sh = '0;
      for (int c = 0; c < 4; c++) begin
         for (int r = 0; r < 4; r++) begin
            if (inv) begin
               sh[127 - 8*(((c+r)%4)*4 + r) -: 8] = get_byte(s, c*4 + r);
            end else begin
               sh[127 - 8*(c*4 + r) -: 8] = get_byte(s, ((c+r)%4)*4 + r);
            end
         end
      end
      for (int n = 0; n < 16; n++) begin
         sb[127 - 8*n -: 8] = inv ? REV_BOX[get_byte(sh, n)] : FWD_BOX[get_byte(sh, n)];
      end
      for (int c = 0; c < 4; c++) begin
         mc[127 - 32*c -: 32] = mix_col(sb[127 - 32*c -: 32], 1'b0);
      end
      round_core = (inv || last) ? sb : mc;
   endfunction

   typedef struct packed {
      logic         valid;
      logic         op;
      logic [127:0] state;
      logic [127:0] key;
   } beat_type;

endpackage

>>> rtl/aes_key_cell.sv
// Final round key derivation: one forward expansion step per stage.
// Depends on aes_pkg.
module aes_key_cell #(
   parameter int unsigned STEP = 0
) (
   input  logic         clock,
   input  logic [127:0] key_in,
   output logic [127:0] key_out
);
   logic [127:0] key_ff;
   logic [127:0] key_in_next;

   assign key_in_next = aes_pkg::key_step(key_in, aes_pkg::RCON[STEP]);

   always_ff @(posedge clock) begin
      key_ff <= key_in_next;
   end

   assign key_out = key_ff;
endmodule

>>> rtl/aes_round_cell.sv
// One cipher round cell: round transform, key add, round key update.
// Depends on aes_pkg.
module aes_round_cell #(
   parameter int unsigned ROUND = 1
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               advance,
   input  aes_pkg::beat_type  beat_in,
   output aes_pkg::beat_type  beat_out
);
   aes_pkg::beat_type beat_ff;
   aes_pkg::beat_type beat_in_next;
   logic [127:0] enc_key;
   logic [127:0] dec_key;
   logic [127:0] core;
   logic         last;

   assign last = (ROUND == aes_pkg::NumRounds);
   assign enc_key = aes_pkg::key_step(beat_in.key, aes_pkg::RCON[ROUND-1]);
   assign dec_key = aes_pkg::key_back(beat_in.key, aes_pkg::RCON[aes_pkg::NumRounds - ROUND]);
   assign core = aes_pkg::round_core(beat_in.state, beat_in.op, last);

   always_comb begin
      beat_in_next.valid = beat_in.valid;
      beat_in_next.op = beat_in.op;
      if (beat_in.op == aes_pkg::OpDecrypt) begin
         beat_in_next.key = dec_key;
         beat_in_next.state = core ^ dec_key;
         if (!last) begin
            for (int c = 0; c < 4; c++) begin
               beat_in_next.state[127 - 32*c -: 32] =
                  aes_pkg::mix_col(beat_in_next.state[127 - 32*c -: 32], 1'b1);
            end
         end
      end else begin
         beat_in_next.key = enc_key;
         beat_in_next.state = core ^ enc_key;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         beat_ff.valid <= 1'b0;
      end else if (advance) begin
         beat_ff.valid <= beat_in_next.valid;
      end
      if (advance) begin
         beat_ff.op <= beat_in_next.op;
         beat_ff.state <= beat_in_next.state;
         beat_ff.key <= beat_in_next.key;
      end
   end

   assign beat_out = beat_ff;
endmodule

>>> rtl/aes128_block_cipher.sv
// AES-128 block cipher top level: key registers, key chain, round pipeline.
// Depends on aes_pkg, aes_key_cell and aes_round_cell.
//
// Usage:
//   csr_valid/csr_ready/csr_index/csr_data write key_high (index 0) and
//   key_low (index 1); other indexes are dropped. Write keys only while idle.
//   req_ beats carry one block: req_tdata = {block_low, block_high}, with
//   block_high from bit 0 up, req_tuser = op (0 encrypt, 1 decrypt).
//   rsp_ beats return the result block, rsp_tdata = {result_low, result_high}.
//   Throughput: one block per cycle while req_tready is high. A block passes
//   one input stage, then one cell per round for ten rounds, to rsp valid.
//   After a key write or reset, the final round key for decryption settles
//   through a ten-stage expansion chain; req_tready stays low until a settle counter reaches zero.
//   The whole pipeline advances as one; when rsp_tready is low and the last
//   cell holds a result, every cell holds and req_tready drops.
//   Reset clears the keys to zero and empties the pipeline.
module aes128_block_cipher (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [127:0] req_tdata,   // block_high[63:0], block_low[127:64]
   input  logic         req_tuser,   // op[0]
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [127:0] rsp_tdata,   // result_high[63:0], result_low[127:64]
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic [aes_pkg::CsrIndexWidth:0] csr_index,
   input  logic [63:0]  csr_data
);
   localparam int unsigned SettleWidth = $clog2(aes_pkg::NumRounds + 1);

   logic [63:0] key_high_ff;
   logic [63:0] key_low_ff;
   logic [127:0] key_chain [aes_pkg::NumRounds+1];
   aes_pkg::beat_type beat [aes_pkg::NumRounds+1];
   aes_pkg::beat_type entry_ff;
   logic [SettleWidth-1:0] settle_ff;
   logic advance;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         key_high_ff <= '0;
         key_low_ff <= '0;
      end else if (csr_valid && csr_index[aes_pkg::CsrIndexWidth] == 1'b0) begin
         unique case (csr_index[aes_pkg::CsrIndexWidth-1:0])
            aes_pkg::CsrKeyHigh: key_high_ff <= csr_data;
            aes_pkg::CsrKeyLow:  key_low_ff <= csr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset || (csr_valid && csr_ready)) begin
         settle_ff <= SettleWidth'(aes_pkg::NumRounds);
      end else if (settle_ff != '0) begin
         settle_ff <= settle_ff - 1'b1;
      end
   end

   assign key_chain[0] = {key_high_ff, key_low_ff};
   for (genvar i = 0; i < aes_pkg::NumRounds; i++) begin : g_key
      aes_key_cell #(.STEP(i)) u_key (
         .clock  (clock),
         .key_in (key_chain[i]),
         .key_out(key_chain[i+1])
      );
   end

   assign advance = !beat[aes_pkg::NumRounds].valid || rsp_tready;
   assign req_tready = advance && (settle_ff == '0);

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_ff.valid <= 1'b0;
      end else if (advance) begin
         entry_ff.valid <= req_tvalid && req_tready;
      end
      if (advance) begin
         entry_ff.op <= req_tuser;
         if (req_tuser == aes_pkg::OpDecrypt) begin
            entry_ff.key <= key_chain[aes_pkg::NumRounds];
            entry_ff.state <= {req_tdata[63:0], req_tdata[127:64]}
                              ^ key_chain[aes_pkg::NumRounds];
         end else begin
            entry_ff.key <= key_chain[0];
            entry_ff.state <= {req_tdata[63:0], req_tdata[127:64]} ^ key_chain[0];
         end
      end
   end

   assign beat[0] = entry_ff;
   for (genvar r = 1; r <= aes_pkg::NumRounds; r++) begin : g_round
      aes_round_cell #(.ROUND(r)) u_round (
         .clock   (clock),
         .reset   (reset),
         .advance (advance),
         .beat_in (beat[r-1]),
         .beat_out(beat[r])
      );
   end

   assign rsp_tvalid = beat[aes_pkg::NumRounds].valid;
   assign rsp_tdata = {beat[aes_pkg::NumRounds].state[63:0],
                       beat[aes_pkg::NumRounds].state[127:64]};
endmodule

>>> tb/aes128_block_cipher_test.sv
// Testbench for aes128_block_cipher: drives blocks and key writes on the
// stream and CSR ports and checks every result against an in-bench AES-128.
// Depends on aes_pkg (CSR indexes, op codes, S-box tables) and the RTL.
module aes128_block_cipher_test;
   import aes_pkg::*;

   localparam int CycleLimit = 200000;
   localparam int SettleCycles = 16;
   localparam logic [CsrIndexWidth:0] CsrSpareA = 2'd2;
   localparam logic [CsrIndexWidth:0] CsrSpareB = 2'd3;

   typedef struct {
      logic [63:0] result_high;
      logic [63:0] result_low;
   } cipher_out_type;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [127:0] req_tdata = '0;
   logic         req_tuser = 1'b0;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [127:0] rsp_tdata;
   logic         csr_valid = 1'b0;
   logic         csr_ready;
   logic [CsrIndexWidth:0] csr_index = '0;
   logic [63:0]  csr_data = '0;

   cipher_out_type pending_blocks[$];
   logic [63:0]  key_hi_shadow = '0;
   logic [63:0]  key_lo_shadow = '0;
   int           errors = 0;
   int           cycles = 0;
   int           tx_idle_pct = 0;
   int           rx_idle_pct = 0;
   int           rx_hold = 0;

   aes128_block_cipher u_top (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_data(csr_data)
   );

   always #6 clock = ~clock;

   function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] m);
      logic [7:0] acc;
      acc = '0;
      for (int b = 0; b < 4; b++) begin
         if (m[b]) acc = acc ^ a;
         a = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
      end
      return acc;
   endfunction

   function automatic logic [127:0] aes_transform(input logic dec, input logic [127:0] key,
                                                  input logic [127:0] blk);
      logic [7:0] rk [176];
      logic [7:0] s [16];
      logic [7:0] t [16];
      logic [7:0] w [4];
      logic [7:0] first;
      logic [7:0] coef [4];
      logic [127:0] res;
      int rnd;
      for (int n = 0; n < 16; n++) begin
         rk[n] = key[127 - 8*n -: 8];
         s[n] = blk[127 - 8*n -: 8];
      end
      for (int n = 4; n < 44; n++) begin
         for (int k = 0; k < 4; k++) w[k] = rk[(n-1)*4 + k];
         if (n % 4 == 0) begin
            first = w[0];
            w[0] = FWD_BOX[w[1]] ^ RCON[n/4 - 1];
            w[1] = FWD_BOX[w[2]];
            w[2] = FWD_BOX[w[3]];
            w[3] = FWD_BOX[first];
         end
         for (int k = 0; k < 4; k++) rk[n*4 + k] = rk[(n-4)*4 + k] ^ w[k];
      end
      if (dec) coef = '{8'he, 8'hb, 8'hd, 8'h9};
      else coef = '{8'h2, 8'h3, 8'h1, 8'h1};
      for (int n = 0; n < 16; n++) s[n] = s[n] ^ rk[(dec ? 160 : 0) + n];
      for (int step = 1; step <= 10; step++) begin
         rnd = dec ? 10 - step : step;
         for (int c = 0; c < 4; c++) begin
            for (int r = 0; r < 4; r++) begin
               if (dec) t[((c+r)%4)*4 + r] = s[c*4 + r];
               else t[c*4 + r] = s[((c+r)%4)*4 + r];
            end
         end
         for (int n = 0; n < 16; n++) s[n] = dec ? REV_BOX[t[n]] : FWD_BOX[t[n]];
         if (dec) begin
            for (int n = 0; n < 16; n++) s[n] = s[n] ^ rk[rnd*16 + n];
         end
         if (step < 10) begin
            for (int c = 0; c < 4; c++) begin
               for (int r = 0; r < 4; r++) begin
                  t[r] = '0;
                  for (int k = 0; k < 4; k++) t[r] = t[r] ^ gf_mul(s[c*4 + k], coef[(k-r+4)%4]);
               end
               for (int r = 0; r < 4; r++) s[c*4 + r] = t[r];
            end
         end
         if (!dec) begin
            for (int n = 0; n < 16; n++) s[n] = s[n] ^ rk[rnd*16 + n];
         end
      end
      for (int n = 0; n < 16; n++) res[127 - 8*n -: 8] = s[n];
      return res;
   endfunction

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CycleLimit) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (rx_hold > 0) begin
         rsp_tready <= 1'b0;
         rx_hold <= rx_hold - 1;
      end else begin
         rsp_tready <= ($urandom_range(99) >= rx_idle_pct);
      end
   end

   always @(posedge clock) begin
      cipher_out_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_blocks.size() == 0) begin
            $display("%0t: unexpected beat, actual %h", $time, rsp_tdata);
            errors++;
         end else begin
            want = pending_blocks.pop_front();
            if (rsp_tdata[63:0] !== want.result_high) begin
               $display("%0t: result_high expected %h actual %h", $time,
                        want.result_high, rsp_tdata[63:0]);
               errors++;
            end
            if (rsp_tdata[127:64] !== want.result_low) begin
               $display("%0t: result_low expected %h actual %h", $time,
                        want.result_low, rsp_tdata[127:64]);
               errors++;
            end
         end
      end
   end

   task automatic wait_drain();
      while (pending_blocks.size() != 0) @(posedge clock);
      repeat (SettleCycles) @(posedge clock);
   endtask

   task automatic write_key(input logic [CsrIndexWidth:0] idx, input logic [63:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= data;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      if (idx == CsrKeyHigh) key_hi_shadow = data;
      else if (idx == CsrKeyLow) key_lo_shadow = data;
   endtask

   task automatic load_key(input logic [63:0] hi, input logic [63:0] lo);
      wait_drain();
      write_key(CsrKeyHigh, hi);
      write_key(CsrKeyLow, lo);
      repeat (SettleCycles) @(posedge clock);
   endtask

   task automatic send_block(input logic op, input logic [63:0] hi, input logic [63:0] lo);
      logic [127:0] res;
      cipher_out_type want;
      req_tvalid <= 1'b1;
      req_tuser <= op;
      req_tdata <= {lo, hi};
      do @(posedge clock); while (!req_tready);
      res = aes_transform(op, {key_hi_shadow, key_lo_shadow}, {hi, lo});
      want.result_high = res[127:64];
      want.result_low = res[63:0];
      pending_blocks.push_back(want);
      if ($urandom_range(99) < tx_idle_pct) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
   endtask

   task automatic stop_sending();
      req_tvalid <= 1'b0;
      @(posedge clock);
   endtask

   function automatic logic [63:0] rand64();
      return {$urandom, $urandom};
   endfunction

   task automatic test_directed();
      load_key(64'h0001020304050607, 64'h08090a0b0c0d0e0f);
      send_block(OpEncrypt, 64'h0011223344556677, 64'h8899aabbccddeeff);
      send_block(OpDecrypt, 64'h69c4e0d86a7b0430, 64'hd8cdb78070b4c55a);
      send_block(OpEncrypt, '0, '0);
      send_block(OpDecrypt, '1, '1);
      stop_sending();
      load_key('0, '0);
      send_block(OpEncrypt, '0, '0);
      send_block(OpDecrypt, '0, '0);
      send_block(OpEncrypt, '1, '1);
      stop_sending();
      load_key('1, '1);
      send_block(OpEncrypt, '1, '0);
      send_block(OpDecrypt, '0, '1);
      send_block(OpEncrypt, 64'h8000000000000000, 64'h0000000000000001);
      stop_sending();
      wait_drain();
      write_key(CsrSpareA, rand64());
      write_key(CsrSpareB, rand64());
      repeat (SettleCycles) @(posedge clock);
      send_block(OpEncrypt, 64'h0123456789abcdef, 64'hfedcba9876543210);
      send_block(OpDecrypt, 64'h0123456789abcdef, 64'hfedcba9876543210);
      stop_sending();
   endtask

   task automatic test_random(input int tx_pct, input int rx_pct, input int count);
      tx_idle_pct = tx_pct;
      rx_idle_pct = rx_pct;
      load_key(rand64(), rand64());
      for (int i = 0; i < count; i++) begin
         if (i == count / 2) begin
            stop_sending();
            load_key(rand64(), rand64());
         end
         send_block($urandom_range(1), rand64(), rand64());
      end
      stop_sending();
   endtask

   task automatic test_backpressure();
      tx_idle_pct = 0;
      rx_idle_pct = 0;
      load_key(rand64(), rand64());
      rx_hold = 150;
      for (int i = 0; i < 60; i++) send_block($urandom_range(1), rand64(), rand64());
      stop_sending();
   endtask

   task automatic test_sender_pause();
      tx_idle_pct = 10;
      rx_idle_pct = 20;
      for (int i = 0; i < 20; i++) send_block($urandom_range(1), rand64(), rand64());
      stop_sending();
      wait_drain();
      for (int i = 0; i < 20; i++) send_block($urandom_range(1), rand64(), rand64());
      stop_sending();
   endtask

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_random(29, 49, 260);
      test_random(49, 29, 260);
      test_random(0, 0, 200);
      test_backpressure();
      test_sender_pause();
      wait_drain();
      if (errors == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end
endmodule
